// File: sv/debounced_button_to_midi_event_unit_macros.svh
// Assertion macros shared by the button-to-MIDI RTL.
// Needs nothing else; included by the top level, the file that carries assertions.
`ifndef DEBOUNCED_BUTTON_TO_MIDI_EVENT_UNIT_MACROS_SVH
`define DEBOUNCED_BUTTON_TO_MIDI_EVENT_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define BDM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define BDM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/bdm_pkg.sv
// Shared types and constants of the button-to-MIDI event unit.
// No dependencies; used by the interfaces and every module.
package bdm_pkg;

    // Debounce history
    localparam int HIST_W = 8;
    localparam logic [HIST_W-1:0] HIST_TOP = 8'b1000_0000;
    localparam logic [HIST_W-1:0] HIST_ALL = 8'hFF;

    // Field widths
    localparam int IDX_W     = 6;
    localparam int MSG_W     = 2;
    localparam int NUM_W     = 7;
    localparam int VAL_W     = 7;
    localparam int CHAN_W    = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 7;

    localparam int NUM_BUTTONS_DEF = 64;

    // Reset values of the settings
    localparam logic [CHAN_W-1:0] NOTE_CHAN_RST = 5'd1;
    localparam logic [CHAN_W-1:0] PROG_CHAN_RST = 5'd1;
    localparam logic [VAL_W-1:0]  ON_VEL_RST    = 7'd127;
    localparam logic [VAL_W-1:0]  OFF_VEL_RST   = 7'd0;

    localparam logic MODE_LATCHING = 1'b1;

    typedef enum logic [MSG_W-1:0] {
        MSG_NOTE = 2'd0,
        MSG_CC   = 2'd1,
        MSG_PC   = 2'd2
    } msg_kind_t;

    typedef enum logic [1:0] {
        KIND_NOTE_ON  = 2'd0,
        KIND_NOTE_OFF = 2'd1,
        KIND_CC       = 2'd2,
        KIND_PC       = 2'd3
    } evt_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NOTE_CHANNEL    = 2'd0,
        CFG_PROGRAM_CHANNEL = 2'd1,
        CFG_ON_VELOCITY     = 2'd2,
        CFG_OFF_VELOCITY    = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [IDX_W-1:0] button_index;
        logic             raw_level;
        logic             use_debounce;
        logic             encoder_member;
        logic             button_mode;
        logic [MSG_W-1:0] message_kind;
        logic [NUM_W-1:0] midi_number;
    } item_t;

    typedef struct packed {
        logic              event_valid;
        logic [1:0]        event_kind;
        logic [NUM_W-1:0]  event_number;
        logic [VAL_W-1:0]  event_value;
        logic [CHAN_W-1:0] event_channel;
    } evt_t;

    typedef struct packed {
        logic [HIST_W-1:0] history;
        logic              pressed;
        logic              prev_level;
    } btn_state_t;

    typedef struct packed {
        logic [CHAN_W-1:0] note_channel;
        logic [CHAN_W-1:0] program_channel;
        logic [VAL_W-1:0]  on_velocity;
        logic [VAL_W-1:0]  off_velocity;
    } cfg_t;

endpackage

// File: sv/bdm_if.sv
// Valid/ready channel interfaces: button samples, MIDI events, settings writes.
// Depends on bdm_pkg.
interface bdm_in_if;
    import bdm_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] button_index;
    logic             raw_level;
    logic             use_debounce;
    logic             encoder_member;
    logic             button_mode;
    logic [MSG_W-1:0] message_kind;
    logic [NUM_W-1:0] midi_number;

    modport source (output valid, button_index, raw_level, use_debounce, encoder_member,
                    button_mode, message_kind, midi_number, input ready);
    modport sink (input valid, button_index, raw_level, use_debounce, encoder_member,
                  button_mode, message_kind, midi_number, output ready);
endinterface

interface bdm_out_if;
    import bdm_pkg::*;
    logic              valid;
    logic              ready;
    logic              event_valid;
    logic [1:0]        event_kind;
    logic [NUM_W-1:0]  event_number;
    logic [VAL_W-1:0]  event_value;
    logic [CHAN_W-1:0] event_channel;

    modport source (output valid, event_valid, event_kind, event_number, event_value,
                    event_channel, input ready);
    modport sink (input valid, event_valid, event_kind, event_number, event_value,
                  event_channel, output ready);
endinterface

interface bdm_cfg_if;
    import bdm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: sv/bdm_cfg_regs.sv
// Settings registers (channels and velocities) behind the write channel.
// Depends on bdm_pkg and bdm_if.
module bdm_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    bdm_cfg_if.sink       cfg,
    output bdm_pkg::cfg_t cfg_regs
);
    import bdm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are always taken
    assign cfg.ready = 1'b1;
    assign cfg_regs  = cfg_reg;

    // Register decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_NOTE_CHANNEL:    cfg_next.note_channel    = cfg.data[CHAN_W-1:0];
                CFG_PROGRAM_CHANNEL: cfg_next.program_channel = cfg.data[CHAN_W-1:0];
                CFG_ON_VELOCITY:     cfg_next.on_velocity     = cfg.data[VAL_W-1:0];
                CFG_OFF_VELOCITY:    cfg_next.off_velocity    = cfg.data[VAL_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.note_channel    <= NOTE_CHAN_RST;
            cfg_reg.program_channel <= PROG_CHAN_RST;
            cfg_reg.on_velocity     <= ON_VEL_RST;
            cfg_reg.off_velocity    <= OFF_VEL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: sv/bdm_state_mem.sv
// Per-button state memory (history, pressed, previous level) with valid bits.
// Registered read with write-to-read forwarding. Depends on bdm_pkg.
module bdm_state_mem #(
    parameter int NUM_BUTTONS = bdm_pkg::NUM_BUTTONS_DEF,
    parameter int AW          = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output bdm_pkg::btn_state_t rd_data,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  bdm_pkg::btn_state_t wr_data
);
    import bdm_pkg::*;

    btn_state_t             mem [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] valid_reg;
    btn_state_t             rd_data_reg;

    assign rd_data = rd_data_reg;

    // Storage write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Entry valid bits; an unwritten entry reads as all zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Registered read; a write to the same entry on this edge is forwarded
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else if (valid_reg[rd_addr])
            begin
                rd_data_reg <= mem[rd_addr];
            end
            else
            begin
                rd_data_reg <= '0;
            end
        end
    end

endmodule

// File: sv/bdm_event_logic.sv
// Debounce, momentary/latching decision and MIDI event build for one sample.
// Purely combinational; depends on bdm_pkg.
module bdm_event_logic (
    input  bdm_pkg::item_t      item,
    input  bdm_pkg::btn_state_t state,
    input  bdm_pkg::cfg_t       cfg,
    output logic                emit,
    output bdm_pkg::evt_t       evt,
    output bdm_pkg::btn_state_t next_state
);
    import bdm_pkg::*;

    logic              level;
    logic              accepted;
    logic              momentary;
    logic [HIST_W-1:0] hist_shift;

    always_comb
    begin
        // encoder members always read as released
        level      = item.raw_level & ~item.encoder_member;
        hist_shift = {state.history[HIST_W-2:0], level} | HIST_TOP;
        momentary  = (item.message_kind == MSG_PC) || (item.button_mode != MODE_LATCHING);
        next_state = state;
        accepted   = 1'b1;
        emit       = 1'b0;
        evt        = '0;
        evt.event_valid   = 1'b1;
        evt.event_number  = item.midi_number;
        evt.event_channel = cfg.note_channel;

        // shift debouncer: level stands once the last seven samples agree
        if (item.use_debounce)
        begin
            next_state.history = hist_shift;
            accepted = (hist_shift == HIST_TOP) || (hist_shift == HIST_ALL);
        end

        if (accepted)
        begin
            if (momentary)
            begin
                if (level)
                begin
                    if (!state.pressed)
                    begin
                        next_state.pressed = 1'b1;
                        case (item.message_kind)
                            MSG_PC:
                            begin
                                emit = 1'b1;
                                evt.event_kind    = KIND_PC;
                                evt.event_channel = cfg.program_channel;
                            end
                            MSG_NOTE:
                            begin
                                emit = 1'b1;
                                evt.event_kind  = KIND_NOTE_ON;
                                evt.event_value = cfg.on_velocity;
                            end
                            MSG_CC:
                            begin
                                emit = 1'b1;
                                evt.event_kind  = KIND_CC;
                                evt.event_value = cfg.on_velocity;
                            end
                            default: emit = 1'b0;
                        endcase
                    end
                end
                else if (state.pressed)
                begin
                    next_state.pressed = 1'b0;
                    // program change sends nothing on release
                    case (item.message_kind)
                        MSG_NOTE:
                        begin
                            emit = 1'b1;
                            evt.event_kind  = KIND_NOTE_OFF;
                            evt.event_value = cfg.off_velocity;
                        end
                        MSG_CC:
                        begin
                            emit = 1'b1;
                            evt.event_kind  = KIND_CC;
                            evt.event_value = cfg.off_velocity;
                        end
                        default: emit = 1'b0;
                    endcase
                end
            end
            else if (level && !state.prev_level)
            begin
                // latching: toggle on each press edge, always notes
                emit = 1'b1;
                next_state.pressed = ~state.pressed;
                if (state.pressed)
                begin
                    evt.event_kind  = KIND_NOTE_OFF;
                    evt.event_value = cfg.off_velocity;
                end
                else
                begin
                    evt.event_kind  = KIND_NOTE_ON;
                    evt.event_value = cfg.on_velocity;
                end
            end
            next_state.prev_level = level;
        end
    end

endmodule

// File: sv/debounced_button_to_midi_event_unit.sv
// Debounced button to MIDI event unit, top level.
// Channels: btn_in takes one button sample with its settings per beat;
// evt_out gives one MIDI event beat per sample that causes an event;
// samples that cause no event produce no beat. cfg writes the channel
// and velocity registers (index 0..3) and is always ready.
// An accepted sample enters stage 1 with its state read from the state
// memory, and its event then goes to the output register. Throughput: one
// sample per cycle unless stalled, set by the read-modify-write of the
// per-button state memory; a read of a button written on the same edge is forwarded.
// Samples whose button index is at or beyond NUM_BUTTONS are dropped.
// Reset: all button state reads as zero (per-entry valid bits cleared at
// once), channels reset to 1, on velocity to 127, off velocity to 0; no
// clearing pass, samples are taken from the first cycle after reset.
// Stall: while an event waits in the output register, a sample in the
// working stage that causes no event still moves on; one that causes an
// event holds the stage, and btn_in.ready drops until the event is taken.
// Depends on bdm_pkg, bdm_if, bdm_cfg_regs, bdm_state_mem, bdm_event_logic.
`include "debounced_button_to_midi_event_unit_macros.svh"

module debounced_button_to_midi_event_unit #(
    parameter int NUM_BUTTONS = bdm_pkg::NUM_BUTTONS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    bdm_in_if.sink    btn_in,
    bdm_out_if.source evt_out,
    bdm_cfg_if.sink   cfg
);
    import bdm_pkg::*;

    localparam int AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int XW = (AW > IDX_W) ? AW : IDX_W;

    cfg_t       cfg_regs;
    item_t      in_item;
    logic       accept;
    logic       in_range;
    logic [XW-1:0] idx_ext;
    logic [AW-1:0] rd_addr;

    logic       s1_valid_reg;
    logic       s1_valid_next;
    item_t      s1_item_reg;
    logic       s1_in_range_reg;
    logic [AW-1:0] s1_addr_reg;
    btn_state_t s1_state;
    logic       s1_adv;

    logic       ev_emit;
    evt_t       ev;
    btn_state_t st_next;
    logic       wr_en;
    logic       load_out;

    logic       out_valid_reg;
    logic       out_valid_next;
    evt_t       out_evt_reg;

    // Settings registers
    bdm_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cfg_regs (cfg_regs)
    );

    // Input beat
    assign in_item.button_index   = btn_in.button_index;
    assign in_item.raw_level      = btn_in.raw_level;
    assign in_item.use_debounce   = btn_in.use_debounce;
    assign in_item.encoder_member = btn_in.encoder_member;
    assign in_item.button_mode    = btn_in.button_mode;
    assign in_item.message_kind   = btn_in.message_kind;
    assign in_item.midi_number    = btn_in.midi_number;

    assign idx_ext  = XW'(btn_in.button_index);
    assign rd_addr  = idx_ext[AW-1:0];
    assign in_range = (32'(btn_in.button_index) < NUM_BUTTONS);

    // A dropped sample never waits for the output register
    assign s1_adv       = s1_valid_reg &&
                          (!(ev_emit && s1_in_range_reg) || !out_valid_reg || evt_out.ready);
    assign btn_in.ready = !s1_valid_reg || s1_adv;
    assign accept       = btn_in.valid && btn_in.ready;

    // Per-button state, read on accept, written when the sample leaves stage 1
    assign wr_en = s1_adv && s1_in_range_reg;

    bdm_state_mem #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .AW          (AW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept && in_range),
        .rd_addr (rd_addr),
        .rd_data (s1_state),
        .wr_en   (wr_en),
        .wr_addr (s1_addr_reg),
        .wr_data (st_next)
    );

    // Decision logic for the sample in stage 1
    bdm_event_logic u_logic (
        .item       (s1_item_reg),
        .state      (s1_state),
        .cfg        (cfg_regs),
        .emit       (ev_emit),
        .evt        (ev),
        .next_state (st_next)
    );

    // Stage 1 control
    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg     <= in_item;
            s1_in_range_reg <= in_range;
            s1_addr_reg     <= rd_addr;
        end
    end

    // Output register
    assign load_out = s1_adv && s1_in_range_reg && ev_emit;

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (evt_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_evt_reg <= ev;
        end
    end

    assign evt_out.valid         = out_valid_reg;
    assign evt_out.event_valid   = out_evt_reg.event_valid;
    assign evt_out.event_kind    = out_evt_reg.event_kind;
    assign evt_out.event_number  = out_evt_reg.event_number;
    assign evt_out.event_value   = out_evt_reg.event_value;
    assign evt_out.event_channel = out_evt_reg.event_channel;

    // Assertions
    `BDM_ASSERT_NEXT(a_fwd_same_button, clk, rst_n,
        accept && in_range && wr_en && (s1_addr_reg == rd_addr),
        s1_state == $past(st_next),
        "state write not forwarded to next read of same button")
    `BDM_ASSERT_IMPL(a_load_when_free, clk, rst_n, load_out,
        !out_valid_reg || evt_out.ready, "event loaded over an untaken event")
    `BDM_ASSERT_NEXT(a_load_shows, clk, rst_n, load_out,
        evt_out.valid && evt_out.event_valid, "loaded event not presented")
    `BDM_ASSERT_IMPL(a_pc_value_zero, clk, rst_n,
        evt_out.valid && (evt_out.event_kind == KIND_PC),
        evt_out.event_value == '0, "program change with nonzero value")

endmodule
